/* design/mxp_pkg.sv */
// ----------------------------------------------------------------------------
// mxp_pkg
// shared constants, types and helpers of the 2x2 stride-2 max pooling stream
// ----------------------------------------------------------------------------
package mxp_pkg;

   // largest map side and channel count the block supports
   localparam int MAX_SIDE     = 256;
   localparam int MAX_CHANNELS = 1024;

   // field and register widths
   localparam int PIX_W      = 16;
   localparam int CHAN_CFG_W = 11;
   localparam int SIDE_CFG_W = 9;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   // counter widths
   localparam int COL_W   = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
   localparam int SIDE_EW = COL_W + 1;
   localparam int CHAN_W  = $clog2(MAX_CHANNELS);
   localparam int CHAN_EW = CHAN_W + 1;

   // line store: one bank for even columns, one for odd columns
   localparam int BANK_DEPTH = (MAX_SIDE + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   // command queue between front and back, depth a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SIDE_LENGTH   = 1'b1;

   typedef enum logic [1:0] {
      OP_STORE,   // first row of a pair: write pixel to line store
      OP_LOAD,    // second row, even column: hold pixel, fetch stored pair
      OP_EMIT     // second row, odd column: window complete
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic                     bank;
      logic [BANK_AW-1:0]       addr;
      logic signed [PIX_W-1:0]  pixel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic signed [PIX_W-1:0] max2(input logic signed [PIX_W-1:0] a,
                                                    input logic signed [PIX_W-1:0] b);
      max2 = (b > a) ? b : a;
   endfunction

endpackage

/* design/mxp_ram.sv */
// ----------------------------------------------------------------------------
// mxp_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mxp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/mxp_front.sv */
// ----------------------------------------------------------------------------
// mxp_front
// raster position tracking and classification of each accepted pixel
// ----------------------------------------------------------------------------
module mxp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic signed [mxp_pkg::PIX_W-1:0]  pixel,
   input  logic [mxp_pkg::CHAN_CFG_W-1:0]    channel_count,
   input  logic [mxp_pkg::SIDE_CFG_W-1:0]    side_length,
   output mxp_pkg::cmd_type                  cmd
);
   import mxp_pkg::*;

   logic [COL_W-1:0]   col_ff, col_in, col_e;
   logic [COL_W-1:0]   row_ff, row_in, row_e;
   logic [CHAN_W-1:0]  chan_ff, chan_in, chan_e;
   logic [SIDE_EW-1:0] side_e, rows_e, col_nx, row_nx;
   logic [CHAN_EW-1:0] chan_lim, chan_nx;

   // clamp configuration to the supported ranges
   always_comb begin
      if (side_length < SIDE_CFG_W'(2)) begin
         side_e = SIDE_EW'(2);
      end else if (int'(side_length) > MAX_SIDE) begin
         side_e = SIDE_EW'(MAX_SIDE);
      end else begin
         side_e = SIDE_EW'(side_length);
      end
      if (channel_count == '0) begin
         chan_lim = CHAN_EW'(1);
      end else if (int'(channel_count) > MAX_CHANNELS) begin
         chan_lim = CHAN_EW'(MAX_CHANNELS);
      end else begin
         chan_lim = CHAN_EW'(channel_count);
      end
   end

   assign rows_e = {side_e[SIDE_EW-1:1], 1'b0};

   // counters at or past a shrunk limit restart at zero
   assign col_e  = ({1'b0, col_ff} >= side_e) ? '0 : col_ff;
   assign row_e  = ({1'b0, row_ff} >= rows_e) ? '0 : row_ff;
   assign chan_e = ({1'b0, chan_ff} >= chan_lim) ? '0 : chan_ff;

   assign col_nx  = {1'b0, col_e} + SIDE_EW'(1);
   assign row_nx  = {1'b0, row_e} + SIDE_EW'(1);
   assign chan_nx = {1'b0, chan_e} + CHAN_EW'(1);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      chan_in = chan_ff;
      if (accept) begin
         if (col_nx >= side_e) begin
            col_in = '0;
            if (row_nx >= rows_e) begin
               row_in  = '0;
               chan_in = (chan_nx >= chan_lim) ? '0 : chan_nx[CHAN_W-1:0];
            end else begin
               row_in  = row_nx[COL_W-1:0];
               chan_in = chan_e;
            end
         end else begin
            col_in  = col_nx[COL_W-1:0];
            row_in  = row_e;
            chan_in = chan_e;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         chan_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         chan_ff <= chan_in;
      end
   end

   always_comb begin
      if (!row_e[0]) begin
         cmd.op = OP_STORE;
      end else if (!col_e[0]) begin
         cmd.op = OP_LOAD;
      end else begin
         cmd.op = OP_EMIT;
      end
      cmd.bank  = col_e[0];
      cmd.addr  = BANK_AW'(col_e >> 1);
      cmd.pixel = pixel;
   end

endmodule

/* design/mxp_queue.sv */
// ----------------------------------------------------------------------------
// mxp_queue
// short command fifo between the classifying front and the executing back
// ----------------------------------------------------------------------------
module mxp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mxp_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output mxp_pkg::cmd_type           head,
   output mxp_pkg::queue_status_type  status
);
   import mxp_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("push into full command queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("pop from empty command queue");

endmodule

/* design/mxp_back.sv */
// ----------------------------------------------------------------------------
// mxp_back
// line store access, window maximum and output register
// ----------------------------------------------------------------------------
module mxp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  mxp_pkg::cmd_type                  head,
   input  mxp_pkg::queue_status_type         status,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic signed [mxp_pkg::PIX_W-1:0]  rsp_tdata
);
   import mxp_pkg::*;

   logic                     we_even, we_odd, re;
   logic [PIX_W-1:0]         rd_even, rd_odd;
   logic signed [PIX_W-1:0]  hold_ff, hold_in;
   logic signed [PIX_W-1:0]  win_max;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0]  rsp_data_ff, rsp_data_in;

   // an emit waits only while the output register is full and not taken
   assign pop = !status.empty &&
                ((head.op != OP_EMIT) || !rsp_valid_ff || rsp_tready);

   assign we_even = pop && (head.op == OP_STORE) && !head.bank;
   assign we_odd  = pop && (head.op == OP_STORE) &&  head.bank;
   assign re      = pop && (head.op == OP_LOAD);

   mxp_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_even_bank (
      .clock (clock),
      .we    (we_even),
      .waddr (head.addr),
      .wdata (head.pixel),
      .re    (re),
      .raddr (head.addr),
      .rdata (rd_even)
   );

   mxp_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_odd_bank (
      .clock (clock),
      .we    (we_odd),
      .waddr (head.addr),
      .wdata (head.pixel),
      .re    (re),
      .raddr (head.addr),
      .rdata (rd_odd)
   );

   assign win_max = max2(max2(signed'(rd_even), signed'(rd_odd)),
                         max2(hold_ff, head.pixel));

   always_comb begin
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         unique case (head.op)
            OP_STORE: begin
            end
            OP_LOAD: begin
               hold_in = head.pixel;
            end
            OP_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = win_max;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_emit_has_room : assert property (@(posedge clock) disable iff (reset)
      (pop && head.op == OP_EMIT) |-> (!rsp_valid_ff || rsp_tready))
      else $error("window result would overwrite a pending result");

   a_load_holds_pixel : assert property (@(posedge clock) disable iff (reset)
      (pop && head.op == OP_LOAD) |=> (hold_ff == $past(head.pixel)))
      else $error("left pixel not held after load");

endmodule

/* design/maxpool_2x2_stride2_stream_top.sv */
// ----------------------------------------------------------------------------
// maxpool_2x2_stride2_stream_top
// 2x2 stride-2 max pooling over a raster stream of square signed Q8.8 maps
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one pixel per transaction, raster order, channel after
//   channel. rsp_* carries one pooled pixel per completed 2x2 window, emitted
//   on the odd column of the second row of each row pair. an odd last column
//   is consumed without effect; an odd last row opens the next channel.
//   csr_* writes channel_count (index 0) and side_length (index 1); write only
//   while no pixel is in flight. csr_ready is always high.
// throughput and path:
//   one pixel per cycle sustained while rsp_tready is high. a result passes
//   the command queue and the output register once its window is complete.
//   the line store is two banks (even / odd column) of MAX_SIDE/2 entries with
//   registered read; the pair above a window is fetched on the even column.
// reset:
//   synchronous, active high; position counters clear, registers go to 16
//   channels and side 256. the line store needs no clearing.
// stall:
//   a 4-deep command queue and the output register decouple the sides; when
//   rsp_tready is low the queue fills and req_tready drops once it is full.
// ----------------------------------------------------------------------------
module maxpool_2x2_stride2_stream_top (
   input  logic                              clock,
   input  logic                              reset,
   // pixel input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mxp_pkg::PIX_W-1:0]         req_tdata,   // [15:0] pixel
   // pooled output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mxp_pkg::PIX_W-1:0]         rsp_tdata,   // [15:0] pooled
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mxp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mxp_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mxp_pkg::*;

   logic [CHAN_CFG_W-1:0]  chan_count_ff, chan_count_in;
   logic [SIDE_CFG_W-1:0]  side_len_ff, side_len_in;
   logic                   req_accept;
   cmd_type                front_cmd;
   cmd_type                queue_head;
   queue_status_type       queue_status;
   logic                   back_pop;
   logic signed [PIX_W-1:0] pooled;

   // configuration registers, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      chan_count_in = chan_count_ff;
      side_len_in   = side_len_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT: chan_count_in = csr_data[CHAN_CFG_W-1:0];
            REG_SIDE_LENGTH:   side_len_in   = csr_data[SIDE_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= CHAN_CFG_W'(16);
         side_len_ff   <= SIDE_CFG_W'(256);
      end else begin
         chan_count_ff <= chan_count_in;
         side_len_ff   <= side_len_in;
      end
   end

   // input is taken whenever the queue has a free slot
   assign req_tready = !queue_status.full;
   assign req_accept = req_tvalid && req_tready;

   mxp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .pixel         (signed'(req_tdata)),
      .channel_count (chan_count_ff),
      .side_length   (side_len_ff),
      .cmd           (front_cmd)
   );

   mxp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_cmd (front_cmd),
      .pop      (back_pop),
      .head     (queue_head),
      .status   (queue_status)
   );

   mxp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (queue_head),
      .status     (queue_status),
      .pop        (back_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (pooled)
   );

   assign rsp_tdata = unsigned'(pooled);

endmodule

/* tb/maxpool_2x2_stride2_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maxpool_2x2_stride2_stream_checker
// watches the pixel, result and register channels, predicts every pooled
// window from the accepted pixels and compares it with the result stream
// ----------------------------------------------------------------------------
module maxpool_2x2_stride2_stream_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [mxp_pkg::PIX_W-1:0]         req_tdata,   // [15:0] pixel
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [mxp_pkg::PIX_W-1:0]         rsp_tdata,   // [15:0] pooled
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [mxp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mxp_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                mismatch_count,
   output int                                pooled_count,
   output int                                pooled_pending,
   output logic                              at_pair_start
);

   // register copies
   logic [mxp_pkg::CHAN_CFG_W-1:0] chan_cfg;
   logic [mxp_pkg::SIDE_CFG_W-1:0] side_cfg;

   // position and line store of the pooling window
   logic signed [mxp_pkg::PIX_W-1:0] line_store [mxp_pkg::MAX_SIDE];
   logic signed [mxp_pkg::PIX_W-1:0] left_hold;
   int unsigned                      col_pos;
   int unsigned                      row_pos;
   int unsigned                      chan_pos;

   // pooled values still owed by the block, oldest first
   logic signed [mxp_pkg::PIX_W-1:0] pooled_due_q [$];
   logic signed [mxp_pkg::PIX_W-1:0] pooled_due;

   function automatic int unsigned side_eff();
      if (side_cfg < 2) return 2;
      if (side_cfg > mxp_pkg::MAX_SIDE) return mxp_pkg::MAX_SIDE;
      return side_cfg;
   endfunction

   function automatic int unsigned chan_eff();
      if (chan_cfg < 1) return 1;
      if (chan_cfg > mxp_pkg::MAX_CHANNELS) return mxp_pkg::MAX_CHANNELS;
      return chan_cfg;
   endfunction

   task automatic pool_pixel(input logic signed [mxp_pkg::PIX_W-1:0] px);
      int unsigned                      side;
      int unsigned                      rows;
      int unsigned                      col;
      logic signed [mxp_pkg::PIX_W-1:0] win_max;
      side = side_eff();
      rows = 2 * (side / 2);
      col  = col_pos;
      // counters left beyond a smaller limit by a register write wrap here
      if (col >= side) col = 0;
      if (row_pos >= rows) row_pos = 0;
      if (chan_pos >= chan_eff()) chan_pos = 0;
      if (row_pos % 2 == 0) begin
         line_store[col] = px;
      end else if (col % 2 == 0) begin
         left_hold = px;
      end else begin
         win_max = line_store[col - 1];
         if (line_store[col] > win_max) win_max = line_store[col];
         if (left_hold > win_max) win_max = left_hold;
         if (px > win_max) win_max = px;
         pooled_due_q.push_back(win_max);
      end
      col++;
      if (col >= side) begin
         col = 0;
         row_pos++;
         if (row_pos >= rows) begin
            row_pos = 0;
            chan_pos++;
            if (chan_pos >= chan_eff()) chan_pos = 0;
         end
      end
      col_pos = col;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         chan_cfg  = (mxp_pkg::CHAN_CFG_W)'(16);
         side_cfg  = (mxp_pkg::SIDE_CFG_W)'(256);
         col_pos   = 0;
         row_pos   = 0;
         chan_pos  = 0;
         left_hold = '0;
         pooled_due_q.delete();
      end else begin
         // results first: a window completed at this edge cannot leave yet
         if (rsp_tvalid && rsp_tready) begin
            pooled_count++;
            if (pooled_due_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: pooled result with none expected, expected none, actual %0d",
                        $time, $signed(rsp_tdata));
            end else begin
               pooled_due = pooled_due_q.pop_front();
               if (rsp_tdata !== pooled_due) begin
                  mismatch_count++;
                  $display("%0t: pooled mismatch, expected %0d, actual %0d",
                           $time, pooled_due, $signed(rsp_tdata));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mxp_pkg::REG_CHANNEL_COUNT: chan_cfg = csr_data;
               mxp_pkg::REG_SIDE_LENGTH:   side_cfg = csr_data[mxp_pkg::SIDE_CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) pool_pixel($signed(req_tdata));
      end
      pooled_pending <= pooled_due_q.size();
      at_pair_start  <= (col_pos == 0) && (row_pos % 2 == 0);
   end

endmodule

/* tb/maxpool_2x2_stride2_stream_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maxpool_2x2_stride2_stream_top_tb
// drives pixel streams through the 2x2 stride-2 max pooling block under a
// range of side lengths and channel counts, with sender gaps and receiver
// stalls; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module maxpool_2x2_stride2_stream_top_tb;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 3;
   localparam int DRAIN_CYCLES   = 16;     // queue is four deep
   localparam int WATCHDOG_LIMIT = 1000;   // cycles without any transaction
   localparam int PHASE_COUNT    = 14;
   localparam int SMALL_PHASE    = 40;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [mxp_pkg::PIX_W-1:0]         req_tdata;    // [15:0] pixel
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [mxp_pkg::PIX_W-1:0]         rsp_tdata;    // [15:0] pooled
   logic                              csr_valid;
   logic                              csr_ready;
   logic [mxp_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [mxp_pkg::CSR_DATA_W-1:0]    csr_data;

   int   mismatch_count;
   int   pooled_count;
   int   pooled_pending;
   logic at_pair_start;

   // idling odds in percent, changed per phase
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int pixels_sent    = 0;
   int reg_writes     = 0;
   int quiet_cycles   = 0;

   maxpool_2x2_stride2_stream_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   maxpool_2x2_stride2_stream_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pooled_count   (pooled_count),
      .pooled_pending (pooled_pending),
      .at_pair_start  (at_pair_start)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // receiver: random stalls at the odds of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: ends the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d pooled results outstanding",
                  $time, WATCHDOG_LIMIT, pooled_pending);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // mostly full-range values, now and then an extreme
   function automatic int random_pixel();
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
         endcase
      end
      return $urandom_range(65535);
   endfunction

   // one pixel transaction; valid stays high afterwards so that back-to-back
   // pixels never lower and raise it in the same step
   task automatic send_pixel(input int value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value[mxp_pkg::PIX_W-1:0];
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   // stop sending and wait until every pooled result has come out
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pooled_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mxp_pkg::CSR_IDX_W-1:0] index,
                            input logic [mxp_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      reg_writes++;
   endtask

   // register writes happen on an idle block at the start of a row pair, so
   // a wider side never reads line store entries that were never written
   task automatic reconfigure(input int channels, input int side);
      logic [mxp_pkg::CSR_DATA_W-1:0] side_word;
      side_word = (mxp_pkg::CSR_DATA_W)'(side);
      // bits above the side field are junk the block must ignore
      side_word[mxp_pkg::CSR_DATA_W-1:mxp_pkg::SIDE_CFG_W] =
         (mxp_pkg::CSR_DATA_W - mxp_pkg::SIDE_CFG_W)'($urandom_range(3));
      settle();
      while (!at_pair_start) begin
         send_pixel(random_pixel());
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      settle();
      write_reg(mxp_pkg::REG_CHANNEL_COUNT, (mxp_pkg::CSR_DATA_W)'(channels));
      write_reg(mxp_pkg::REG_SIDE_LENGTH, side_word);
      csr_valid <= 1'b0;
   endtask

   // one 2x2 window on a side of two: top row a b, bottom row c d
   task automatic send_window(input int a, input int b, input int c, input int d);
      send_pixel(a);
      send_pixel(b);
      send_pixel(c);
      send_pixel(d);
   endtask

   // settings per random phase: clamped, odd, smallest and largest sides
   task automatic phase_plan(input int phase, output int channels, output int side);
      case (phase)
         0:       begin channels = 1;    side = 2;   end
         1:       begin channels = 0;    side = 5;   end
         2:       begin channels = 1024; side = 0;   end
         3:       begin channels = 3;    side = 256; end
         4:       begin channels = 2047; side = 3;   end
         5:       begin channels = 2;    side = 1;   end
         6:       begin channels = 16;   side = 8;   end
         7:       begin channels = 1;    side = 511; end
         8:       begin channels = 1023; side = 4;   end
         9:       begin channels = 5;    side = 17;  end
         10:      begin channels = 1;    side = 6;   end
         11:      begin channels = 0;    side = 2;   end
         12:      begin channels = 7;    side = 31;  end
         default: begin channels = 2;    side = 3;   end
      endcase
   endtask

   initial begin
      int channels;
      int side;
      int phase_pixels;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= mxp_pkg::REG_CHANNEL_COUNT;
      csr_data   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: each window position holding the maximum, full-scale values
      reconfigure(1, 2);
      send_window(-32768, -32768, -32768, -32768);
      send_window(32767, -32768, -1, 0);
      send_window(-2, -1, -32768, -3);
      send_window(0, -1, 256, -256);
      send_window(-32768, -32767, -32768, -32766);

      // odd side: the largest value sits in the ignored last column
      reconfigure(2047, 3);
      send_pixel(0);
      send_pixel(-5);
      send_pixel(32767);
      send_pixel(-7);
      send_pixel(-6);
      send_pixel(32767);

      // random phases, idling modes in turn
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         phase_plan(phase, channels, side);
         reconfigure(channels, side);
         case (phase % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         // large sides get exactly one full row pair
         phase_pixels = (side > 64) ? 2 * mxp_pkg::MAX_SIDE : SMALL_PHASE;
         for (int n = 0; n < phase_pixels; n++) begin
            send_pixel(random_pixel());
            // occasional hold-off until the block has caught up
            if ($urandom_range(149) == 0) settle();
         end
      end

      settle();
      $display("run covered %0d pixel transactions, %0d pooled results, %0d register writes",
               pixels_sent, pooled_count, reg_writes);
      $display("sides 0..511 with odd and clamped ones, channel counts 0..2047, gaps and stalls");
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
